### hdl/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;

  localparam int DELAY_WIDTH_DEF = 16;
  localparam int DELAY_REG_W     = 16;
  localparam logic [DELAY_REG_W-1:0] DELAY_RESET = 16'd100;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_DELAY_TICKS = 1'b0;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NACK    = 3'd6,
    CMD_WAITACK = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t       kind;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

endpackage
`default_nettype wire

### hdl/i2c_master_command_sequencer_top.sv
// I2C master line sequencer.
// Each item on the in_ stream is one tick of the bus sequencer: an optional
// command in in_tuser and the byte to send plus the sampled SDA level in
// in_tdata. A command is taken only while no command is running; otherwise
// it is dropped. Each line phase lasts delay_ticks items (register 0 of the
// APB port, reset 100; zero counts as one).
// Every input item yields exactly one result item on the out_ stream with
// the SCL/SDA drives (1 = released), busy, a one-item done pulse, the last
// received byte and the missing-ACK flag.
// From input acceptance the result passes the input register, then the
// sequencer update into the output register, which drives out_tvalid.
// Throughput is one item per cycle while the output is not stalled; the
// single state update per tick sets it.
// If out_tready is low the output register holds, the input register fills
// and in_tready drops until the result is taken; no item is lost.
// Synchronous reset releases both lines, clears the sequencer to idle,
// empties both registers and restores delay_ticks to 100.
`default_nettype none
module i2c_master_command_sequencer_top import i2cms_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // tx_byte[7:0], sda_in[8], zero[15:9]
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // kind[2:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // scl_out[0], sda_out[1], busy_res[2],
                                                 // done_res[3], rx_byte[11:4],
                                                 // ack_missing[12], zero[15:13]
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic                   in_valid_r, in_valid_nxt;
  item_t                  item_r;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   res_r;
  res_t                   res;
  logic                   step_en;
  logic [DELAY_REG_W-1:0] delay_ticks;

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind    <= cmd_t'(in_tuser);
      item_r.tx_byte <= in_tdata[7:0];
      item_r.sda_in  <= in_tdata[8];
    end
    if (step_en) begin
      res_r <= res;
    end
  end

  i2cms_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .delay_ticks (delay_ticks)
  );

  i2cms_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (item_r),
    .delay_ticks (delay_ticks),
    .res         (res)
  );

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.ack_missing, res_r.rx_byte, res_r.done_res,
                       res_r.busy_res, res_r.sda_out, res_r.scl_out};

endmodule
`default_nettype wire

### hdl/i2cms_cfg.sv
`default_nettype none
module i2cms_cfg import i2cms_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic [DELAY_REG_W-1:0]      delay_ticks
);

  logic [DELAY_REG_W-1:0] delay_r;
  logic [DELAY_REG_W-1:0] delay_nxt;
  logic                   hit;

  // byte lanes below the word index are ignored
  assign hit = (paddr[CFG_ADDR_W-1] == REG_DELAY_TICKS);

  always_comb begin
    delay_nxt = delay_r;
    if (psel && penable && pwrite && hit) begin
      delay_nxt = pwdata[DELAY_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else begin
      delay_r <= delay_nxt;
    end
  end

  assign prdata      = hit ? {{(CFG_DATA_W-DELAY_REG_W){1'b0}}, delay_r} : '0;
  assign delay_ticks = delay_r;

endmodule
`default_nettype wire

### hdl/i2cms_core.sv
`default_nettype none
module i2cms_core import i2cms_pkg::*; #(
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step_en,
  input  wire item_t                  item,
  input  wire logic [DELAY_REG_W-1:0] delay_ticks,
  output res_t                        res
);

  cmd_t                   cmd_r, cmd_nxt;
  logic [1:0]             step_r, step_nxt;
  logic [DELAY_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             sh_r, sh_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   ack_r, ack_nxt;

  logic [DELAY_WIDTH-1:0] dly_masked;
  logic [DELAY_WIDTH-1:0] plen;
  logic [DELAY_WIDTH-1:0] cnt_dec;
  logic [2:0]             bit_inc;
  logic                   finish;
  logic                   done;

  generate
    if (DELAY_WIDTH > DELAY_REG_W) begin : g_wide
      assign dly_masked = {{(DELAY_WIDTH-DELAY_REG_W){1'b0}}, delay_ticks};
    end else if (DELAY_WIDTH == DELAY_REG_W) begin : g_equal
      assign dly_masked = delay_ticks;
    end else begin : g_narrow
      assign dly_masked = delay_ticks[DELAY_WIDTH-1:0];
    end
  endgenerate

  // a zero delay still holds each phase for one tick
  assign plen    = (dly_masked == '0) ? {{(DELAY_WIDTH-1){1'b0}}, 1'b1} : dly_masked;
  assign cnt_dec = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;
  assign bit_inc = bit_r + 3'd1;

  always_comb begin
    cmd_nxt  = cmd_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    bit_nxt  = bit_r;
    sh_nxt   = sh_r;
    rx_nxt   = rx_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    ack_nxt  = ack_r;
    finish   = 1'b0;
    done     = 1'b0;

    if (cmd_r == CMD_NONE) begin
      if (item.kind != CMD_NONE) begin
        cmd_nxt  = item.kind;
        bit_nxt  = 3'd0;
        step_nxt = 2'd0;
        cnt_nxt  = plen;
        case (item.kind)
          CMD_START: begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
          CMD_STOP: begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end
          CMD_WRITE: begin
            sh_nxt  = item.tx_byte;
            scl_nxt = 1'b0;
            sda_nxt = item.tx_byte[7];
          end
          CMD_READ: begin
            sh_nxt  = 8'd0;
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
          end
          CMD_ACK: sda_nxt = 1'b0;
          default: sda_nxt = 1'b1;
        endcase
      end
    end else begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        case (cmd_r)
          CMD_START: begin
            if (step_r == 2'd0) begin
              sda_nxt  = 1'b0;
              step_nxt = 2'd1;
              cnt_nxt  = plen;
            end else begin
              scl_nxt = 1'b0;
              finish  = 1'b1;
            end
          end
          CMD_STOP: begin
            if (step_r == 2'd0) begin
              sda_nxt  = 1'b1;
              step_nxt = 2'd1;
              cnt_nxt  = plen;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_ACK, CMD_NACK, CMD_WAITACK: begin
            if (step_r == 2'd0) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd1;
              cnt_nxt  = plen;
            end else if (step_r == 2'd1) begin
              if (cmd_r == CMD_WAITACK) begin
                ack_nxt = item.sda_in;
              end
              scl_nxt  = 1'b0;
              step_nxt = 2'd2;
              cnt_nxt  = plen;
            end else begin
              if (cmd_r == CMD_ACK) begin
                sda_nxt = 1'b1;
              end
              finish = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (step_r == 2'd0) begin
              scl_nxt  = 1'b1;
              step_nxt = 2'd1;
              cnt_nxt  = plen;
            end else begin
              scl_nxt = 1'b0;
              if (bit_r == 3'd7) begin
                sda_nxt = 1'b1;
                finish  = 1'b1;
              end else begin
                bit_nxt  = bit_inc;
                sda_nxt  = sh_r[3'd7 - bit_inc];
                step_nxt = 2'd0;
                cnt_nxt  = plen;
              end
            end
          end
          CMD_READ: begin
            if (step_r == 2'd0) begin
              // sample at the end of the SCL-high phase
              if (item.sda_in) begin
                sh_nxt[3'd7 - bit_r] = 1'b1;
              end
              scl_nxt  = 1'b0;
              step_nxt = 2'd1;
              cnt_nxt  = plen;
            end else if (bit_r == 3'd7) begin
              rx_nxt = sh_r;
              finish = 1'b1;
            end else begin
              bit_nxt  = bit_inc;
              scl_nxt  = 1'b1;
              step_nxt = 2'd0;
              cnt_nxt  = plen;
            end
          end
          default: finish = 1'b1;
        endcase
      end
      if (finish) begin
        cmd_nxt  = CMD_NONE;
        step_nxt = 2'd0;
        cnt_nxt  = '0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= CMD_NONE;
      step_r <= 2'd0;
      cnt_r  <= '0;
      bit_r  <= 3'd0;
      sh_r   <= 8'd0;
      rx_r   <= 8'd0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
      ack_r  <= 1'b0;
    end else if (step_en) begin
      cmd_r  <= cmd_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
      bit_r  <= bit_nxt;
      sh_r   <= sh_nxt;
      rx_r   <= rx_nxt;
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
      ack_r  <= ack_nxt;
    end
  end

  always_comb begin
    res.scl_out     = scl_nxt;
    res.sda_out     = sda_nxt;
    res.busy_res    = (cmd_nxt != CMD_NONE);
    res.done_res    = done;
    res.rx_byte     = rx_nxt;
    res.ack_missing = ack_nxt;
  end

endmodule
`default_nettype wire

### hdl/i2cms_chk.sv
`default_nettype none
module i2cms_chk import i2cms_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a finished command is never reported as still busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && out_tdata[2]))
    else $error("done and busy together");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the output free, the input side is never blocked
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind i2c_master_command_sequencer_top i2cms_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

### tb/tb.sv
module tb;
  import i2cms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam int STALL_NONE     = 0;
  localparam int STALL_PERIODIC = 1;
  localparam int STALL_RANDOM   = 2;

  localparam logic [CFG_ADDR_W-1:0] DELAY_ADDR = {REG_DELAY_TICKS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;

  localparam int RANDOM_TICKS   = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // tx_byte[7:0], sda_in[8], zero[15:9]
  logic [IN_USER_W-1:0]  in_tuser = '0;   // kind[2:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // scl_out[0], sda_out[1], busy_res[2],
                                          // done_res[3], rx_byte[11:4], ack_missing[12]
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  i2c_master_command_sequencer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sequencer mirror, advanced once per accepted tick
  logic [15:0] seq_delay = DELAY_RESET;
  cmd_t        seq_cmd = CMD_NONE;
  logic [2:0]  seq_step = '0;
  logic [15:0] seq_cnt = '0;
  logic [2:0]  seq_bit = '0;
  logic [7:0]  seq_shift = '0;
  logic [7:0]  seq_rx = '0;
  logic        seq_scl = 1'b1;
  logic        seq_sda = 1'b1;
  logic        seq_ack = 1'b0;

  item_t tick_q[$];
  res_t  line_q[$];
  item_t cur_tick;
  int    ticks_sent = 0;
  int    ticks_seen = 0;
  int    errors = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    quiet_cycles = 0;
  int    stall_cyc = 0;
  int    stall_mode = STALL_NONE;
  bit    gen_noise = 1'b0;
  res_t  mon_got;
  res_t  mon_want;

  function automatic logic [15:0] phase_len();
    return (seq_delay == '0) ? 16'd1 : seq_delay;
  endfunction

  function automatic void enter_phase(input logic [2:0] step);
    seq_step = step;
    seq_cnt  = phase_len();
  endfunction

  // Run the phase that has just timed out; return 1 when the command is complete
  function automatic logic line_advance(input logic sda);
    case (seq_cmd)
      CMD_START: begin
        if (seq_step == 0) begin
          seq_sda = 1'b0;
          enter_phase(3'd1);
          return 1'b0;
        end
        seq_scl = 1'b0;
        return 1'b1;
      end
      CMD_STOP: begin
        if (seq_step == 0) begin
          seq_sda = 1'b1;
          enter_phase(3'd1);
          return 1'b0;
        end
        return 1'b1;
      end
      CMD_ACK, CMD_NACK, CMD_WAITACK: begin
        if (seq_step == 0) begin
          seq_scl = 1'b1;
          enter_phase(3'd1);
          return 1'b0;
        end
        if (seq_step == 1) begin
          if (seq_cmd == CMD_WAITACK) seq_ack = sda;
          seq_scl = 1'b0;
          enter_phase(3'd2);
          return 1'b0;
        end
        if (seq_cmd == CMD_ACK) seq_sda = 1'b1;
        return 1'b1;
      end
      CMD_WRITE: begin
        if (seq_step == 0) begin
          seq_scl = 1'b1;
          enter_phase(3'd1);
          return 1'b0;
        end
        seq_scl = 1'b0;
        if (seq_bit == 3'd7) begin
          seq_sda = 1'b1;
          return 1'b1;
        end
        seq_bit = seq_bit + 3'd1;
        seq_sda = seq_shift[3'd7 - seq_bit];
        enter_phase(3'd0);
        return 1'b0;
      end
      CMD_READ: begin
        if (seq_step == 0) begin
          if (sda) seq_shift[3'd7 - seq_bit] = 1'b1;
          seq_scl = 1'b0;
          enter_phase(3'd1);
          return 1'b0;
        end
        if (seq_bit == 3'd7) begin
          seq_rx = seq_shift;
          return 1'b1;
        end
        seq_bit = seq_bit + 3'd1;
        seq_scl = 1'b1;
        enter_phase(3'd0);
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic res_t predict_line_tick(input item_t t);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (seq_cmd == CMD_NONE) begin
      if (t.kind != CMD_NONE) begin
        seq_cmd = t.kind;
        seq_bit = '0;
        case (t.kind)
          CMD_START: begin
            seq_sda = 1'b1;
            seq_scl = 1'b1;
          end
          CMD_STOP: begin
            seq_sda = 1'b0;
            seq_scl = 1'b1;
          end
          CMD_WRITE: begin
            seq_shift = t.tx_byte;
            seq_scl   = 1'b0;
            seq_sda   = t.tx_byte[7];
          end
          CMD_READ: begin
            seq_shift = '0;
            seq_scl   = 1'b1;
            seq_sda   = 1'b1;
          end
          CMD_ACK: seq_sda = 1'b0;
          default: seq_sda = 1'b1;
        endcase
        enter_phase(3'd0);
      end
    end else begin
      if (seq_cnt != 0) seq_cnt = seq_cnt - 16'd1;
      if (seq_cnt == 0) begin
        if (line_advance(t.sda_in)) begin
          seq_cmd  = CMD_NONE;
          seq_step = '0;
          seq_cnt  = '0;
          fin      = 1'b1;
        end
      end
    end
    r.scl_out     = seq_scl;
    r.sda_out     = seq_sda;
    r.busy_res    = (seq_cmd != CMD_NONE);
    r.done_res    = fin;
    r.rx_byte     = seq_rx;
    r.ack_missing = seq_ack;
    return r;
  endfunction

  function automatic int phases_of(input cmd_t k);
    case (k)
      CMD_START, CMD_STOP:             return 2;
      CMD_ACK, CMD_NACK, CMD_WAITACK:  return 3;
      CMD_WRITE, CMD_READ:             return 16;
      default:                         return 0;
    endcase
  endfunction

  function automatic item_t make_tick(input cmd_t k, input logic [7:0] b, input int sda_sel);
    item_t t;
    t.kind    = k;
    t.tx_byte = b;
    t.sda_in  = (sda_sel == SDA_RANDOM) ? 1'($urandom_range(0, 1)) : (sda_sel == SDA_HIGH);
    return t;
  endfunction

  function automatic void queue_tick(input item_t t);
    tick_q.push_back(t);
    ticks_sent++;
  endfunction

  // Issue a command and enough ticks to carry it to completion, plus slack
  task automatic put_cmd(input cmd_t k, input logic [7:0] b, input int sda_sel,
                         input int slack);
    int    busy_ticks;
    int    i;
    item_t t;
    busy_ticks = phases_of(k) * int'(phase_len());
    queue_tick(make_tick(k, b, sda_sel));
    for (i = 0; i < busy_ticks + slack; i++) begin
      t = make_tick(CMD_NONE, 8'($urandom), sda_sel);
      if (gen_noise && i < busy_ticks && $urandom_range(0, 4) == 0)
        t.kind = cmd_t'($urandom_range(1, 7));
      queue_tick(t);
    end
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (ticks_seen != ticks_sent);
  endtask

  // Drain, run the sequencer to idle, then write one register
  task automatic set_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    wait_drain();
    while (seq_cmd != CMD_NONE) begin
      repeat (256) queue_tick(make_tick(CMD_NONE, 8'($urandom), SDA_RANDOM));
      wait_drain();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == DELAY_ADDR) seq_delay = data[15:0];
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) line_q.push_back(predict_line_tick(cur_tick));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          in_tuser  <= cur_tick.kind;
          in_tdata  <= {7'd0, cur_tick.sda_in, cur_tick.tx_byte};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern (none, periodic or random) is redrawn periodically
  always @(posedge clk) begin
    stall_cyc++;
    if (stall_cyc % 512 == 0) stall_mode = $urandom_range(STALL_NONE, STALL_RANDOM);
    case (stall_mode)
      STALL_NONE:     out_tready <= 1'b1;
      STALL_PERIODIC: out_tready <= (stall_cyc % 19) >= 4;
      default:        out_tready <= $urandom_range(0, 9) >= 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        ticks_seen++;
        mon_got.scl_out     = out_tdata[0];
        mon_got.sda_out     = out_tdata[1];
        mon_got.busy_res    = out_tdata[2];
        mon_got.done_res    = out_tdata[3];
        mon_got.rx_byte     = out_tdata[11:4];
        mon_got.ack_missing = out_tdata[12];
        if (line_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result item: scl %b sda %b busy %b done %b rx %h ackm %b",
                     mon_got.scl_out, mon_got.sda_out, mon_got.busy_res,
                     mon_got.done_res, mon_got.rx_byte, mon_got.ack_missing);
        end else begin
          mon_want = line_q.pop_front();
          if (mon_got !== mon_want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("item %0d: want scl %b sda %b busy %b done %b rx %h ackm %b, got %s",
                       ticks_seen, mon_want.scl_out, mon_want.sda_out, mon_want.busy_res,
                       mon_want.done_res, mon_want.rx_byte, mon_want.ack_missing,
                       $sformatf("scl %b sda %b busy %b done %b rx %h ackm %b",
                                 mon_got.scl_out, mon_got.sda_out, mon_got.busy_res,
                                 mon_got.done_res, mon_got.rx_byte, mon_got.ack_missing));
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int         rand_base;
    int         n_bytes;
    int         j;
    logic [7:0] addr_byte;
    logic [31:0] dly;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset delay of 100 ticks per phase
    put_cmd(CMD_START, 8'h00, SDA_HIGH, 0);
    put_cmd(CMD_STOP, 8'($urandom), SDA_RANDOM, 2);

    set_reg(DELAY_ADDR, 32'd1);
    repeat (3) queue_tick(make_tick(CMD_NONE, 8'($urandom), SDA_RANDOM));
    put_cmd(CMD_START, 8'h00, SDA_RANDOM, 0);
    put_cmd(CMD_WRITE, 8'h00, SDA_RANDOM, 0);
    put_cmd(CMD_WAITACK, 8'hFF, SDA_LOW, 0);
    put_cmd(CMD_WRITE, 8'hFF, SDA_RANDOM, 1);
    put_cmd(CMD_WAITACK, 8'h00, SDA_HIGH, 0);
    put_cmd(CMD_WRITE, 8'hA5, SDA_RANDOM, 0);
    put_cmd(CMD_READ, 8'h00, SDA_HIGH, 0);
    put_cmd(CMD_ACK, 8'h00, SDA_RANDOM, 0);
    put_cmd(CMD_READ, 8'hFF, SDA_LOW, 0);
    put_cmd(CMD_NACK, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_READ, 8'($urandom), SDA_RANDOM, 3);
    // land the next command on the tick the start completes: it must be dropped
    put_cmd(CMD_START, 8'h00, SDA_RANDOM, -1);
    put_cmd(CMD_READ, 8'h00, SDA_RANDOM, 0);
    put_cmd(CMD_STOP, 8'h00, SDA_RANDOM, 0);

    // zero delay behaves as one tick
    set_reg(DELAY_ADDR, 32'd0);
    put_cmd(CMD_START, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_WRITE, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_WAITACK, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_STOP, 8'($urandom), SDA_RANDOM, 0);

    // write to an unmapped register: delay must stay at zero
    set_reg(SPARE_ADDR, $urandom);
    put_cmd(CMD_NACK, 8'($urandom), SDA_RANDOM, 0);

    // upper bits of the write data are dropped
    set_reg(DELAY_ADDR, 32'hFFFF_0002);
    put_cmd(CMD_STOP, 8'($urandom), SDA_RANDOM, 0);

    set_reg(DELAY_ADDR, 32'd3);
    put_cmd(CMD_START, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_READ, 8'($urandom), SDA_RANDOM, 0);
    put_cmd(CMD_ACK, 8'($urandom), SDA_RANDOM, 0);

    gen_noise = 1'b1;
    rand_base = ticks_sent;
    while (ticks_sent - rand_base < RANDOM_TICKS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 7))
          0:       dly = 32'd0;
          1:       dly = $urandom_range(4, 12);
          default: dly = $urandom_range(1, 2);
        endcase
        dly[31:16] = 16'($urandom);
        set_reg(DELAY_ADDR, dly);
      end
      if ($urandom_range(0, 3) != 0) begin
        // well-formed transfer: address, ack, a few data bytes, stop
        addr_byte = 8'($urandom);
        put_cmd(CMD_START, 8'($urandom), SDA_RANDOM, 0);
        if ($urandom_range(0, 5) == 0) wait_drain();
        put_cmd(CMD_WRITE, addr_byte, SDA_RANDOM, 0);
        put_cmd(CMD_WAITACK, 8'($urandom),
                ($urandom_range(0, 4) == 0) ? SDA_HIGH : SDA_LOW, 0);
        n_bytes = $urandom_range(0, 3);
        for (j = 0; j < n_bytes; j++) begin
          if (addr_byte[0]) begin
            put_cmd(CMD_READ, 8'($urandom), SDA_RANDOM, 0);
            if (j == n_bytes - 1) put_cmd(CMD_NACK, 8'($urandom), SDA_RANDOM, 0);
            else put_cmd(CMD_ACK, 8'($urandom), SDA_RANDOM, 0);
          end else begin
            put_cmd(CMD_WRITE, 8'($urandom), SDA_RANDOM, 0);
            put_cmd(CMD_WAITACK, 8'($urandom), SDA_RANDOM, 0);
          end
        end
        put_cmd(CMD_STOP, 8'($urandom), SDA_RANDOM, $urandom_range(0, 4));
      end else begin
        // stray command, possibly cut short so the next one collides
        put_cmd(cmd_t'($urandom_range(0, 7)), 8'($urandom), SDA_RANDOM,
                $urandom_range(0, 6) - 3);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && line_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_cfg.sv
hdl/i2cms_core.sv
hdl/i2c_master_command_sequencer_top.sv
hdl/i2cms_chk.sv
tb/tb.sv
